// ----- sv/gpbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gpbs_pkg: shared types and constants for the grid pocket buriedness scan
// Holds the sequencer states, command and register codes and the table of
// planar walk directions used by the voxel line scan.
// ----------------------------------------------------------------------------
package gpbs_pkg;

  localparam int unsigned MAX_DIM_DEF = 64;

  // compare domain for size registers against MAX_DIM (MAX_DIM <= 256)
  localparam int unsigned SZ_W = 9;

  localparam int unsigned SIZE_REG_W = 7;
  localparam int unsigned THR_W      = 3;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [SIZE_REG_W-1:0] SIZE_RST = 7'd64;
  localparam logic [THR_W-1:0]      THR_RST  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int unsigned NUM_DIRS = 8;
  localparam int unsigned DIR_W    = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_Q_RD,
    ST_Q_EV,
    ST_WALK,
    ST_DONE
  } state_e;

  // planar step in (x,y); diag walks also track z+k and z-k
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic              diag;
  } dir_t;

  // 0:+x 1:-x 2:+y 3:-y 4:(-1,-1) 5:(+1,+1) 6:(+1,-1) 7:(-1,+1)
  function automatic dir_t dir_of(input logic [DIR_W-1:0] d);
    dir_t r;
    case (d)
      3'd0:    r = '{dx:  2'sd1, dy:  2'sd0, diag: 1'b0};
      3'd1:    r = '{dx: -2'sd1, dy:  2'sd0, diag: 1'b0};
      3'd2:    r = '{dx:  2'sd0, dy:  2'sd1, diag: 1'b0};
      3'd3:    r = '{dx:  2'sd0, dy: -2'sd1, diag: 1'b0};
      3'd4:    r = '{dx: -2'sd1, dy: -2'sd1, diag: 1'b1};
      3'd5:    r = '{dx:  2'sd1, dy:  2'sd1, diag: 1'b1};
      3'd6:    r = '{dx:  2'sd1, dy: -2'sd1, diag: 1'b1};
      default: r = '{dx: -2'sd1, dy:  2'sd1, diag: 1'b1};
    endcase
    return r;
  endfunction

endpackage

// ----- sv/grid_pocket_buriedness_scan_top.sv -----
// ----------------------------------------------------------------------------
// grid_pocket_buriedness_scan_top: voxel occupancy grid with buriedness query
// Stores the grid as MAX_DIM^2 rows of MAX_DIM bits (row = x,y; bit = z) and
// scans seven lines through a queried empty voxel.
// ----------------------------------------------------------------------------
// After reset the block clears its grid memory one row per cycle, all
// MAX_DIM^2 rows, and holds in_stall_o high meanwhile; config writes are
// taken at any time. A write word is accepted, its row read and then written
// back; one outside the grid is dropped when accepted. A query word reads the
// voxel's own row, which also settles the z line, then walks eight planar
// directions in (x,y), one row read per cycle from the memory read port,
// each walk ending at the first occupied voxel on both of its z tracks or at
// the grid edge. A new word is accepted while a result waits at the output.
module grid_pocket_buriedness_scan_top #(
  parameter int unsigned MAX_DIM = gpbs_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gpbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [gpbs_pkg::COORD_W-1:0]     coord_x_i,
  input  logic [gpbs_pkg::COORD_W-1:0]     coord_y_i,
  input  logic [gpbs_pkg::COORD_W-1:0]     coord_z_i,
  input  logic                             occupied_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gpbs_pkg::COUNT_W-1:0]     enclosed_count_o,
  output logic                             buried_o,
  output logic                             voxel_occupied_o,
  output logic                             out_of_range_o
);

  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned RAW   = $clog2(DEPTH);
  localparam int unsigned SZ_W  = gpbs_pkg::SZ_W;
  localparam int unsigned DW    = gpbs_pkg::DIR_W;

  // ---------------------------------------------------------------- config
  logic [gpbs_pkg::SIZE_REG_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [gpbs_pkg::THR_W-1:0]      thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= gpbs_pkg::SIZE_RST;
      size_y_q <= gpbs_pkg::SIZE_RST;
      size_z_q <= gpbs_pkg::SIZE_RST;
      thr_q    <= gpbs_pkg::THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpbs_pkg::CFG_SIZE_X: size_x_q <= cfg_data_i;
        gpbs_pkg::CFG_SIZE_Y: size_y_q <= cfg_data_i;
        gpbs_pkg::CFG_SIZE_Z: size_z_q <= cfg_data_i;
        gpbs_pkg::CFG_THR:    thr_q    <= cfg_data_i[gpbs_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated at MAX_DIM
  logic [SZ_W-1:0] gx9, gy9, gz9;
  logic [PW-1:0]   gx, gy, gz;

  assign gx9 = (SZ_W'(size_x_q) > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : SZ_W'(size_x_q);
  assign gy9 = (SZ_W'(size_y_q) > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : SZ_W'(size_y_q);
  assign gz9 = (SZ_W'(size_z_q) > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : SZ_W'(size_z_q);
  assign gx  = gx9[PW-1:0];
  assign gy  = gy9[PW-1:0];
  assign gz  = gz9[PW-1:0];

  logic [SZ_W-1:0] cx9, cy9, cz9;
  logic            in_rng;

  assign cx9    = SZ_W'(coord_x_i);
  assign cy9    = SZ_W'(coord_y_i);
  assign cz9    = SZ_W'(coord_z_i);
  assign in_rng = (cx9 < gx9) && (cy9 < gy9) && (cz9 < gz9);

  // ---------------------------------------------------------------- memory
  logic [MAX_DIM-1:0] mem_q [DEPTH];
  logic [MAX_DIM-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [RAW-1:0]     waddr, raddr;
  logic [MAX_DIM-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  function automatic logic [RAW-1:0] row_addr(input logic [AW-1:0] x,
                                              input logic [AW-1:0] y);
    return RAW'(RAW'(x) * RAW'(MAX_DIM) + RAW'(y));
  endfunction

  // ---------------------------------------------------------------- state
  gpbs_pkg::state_e state_q, state_d;

  logic [RAW-1:0]             clr_q, clr_d;
  logic [AW-1:0]              x_q, x_d, y_q, y_d, z_q, z_d;
  logic                       wocc_q, wocc_d;
  logic                       oor_q, oor_d, occf_q, occf_d;
  logic                       zup_q, zup_d, zdn_q, zdn_d;
  logic [gpbs_pkg::NUM_DIRS-1:0] hp_q, hp_d, hm_q, hm_d;
  logic [DW-1:0]              dir_q, dir_d;
  logic [PW-1:0]              pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [PW-1:0]              k_q, k_d, m_k_q, m_k_d;
  logic                       m_valid_q, m_valid_d, m_inxy_q, m_inxy_d;
  logic                       pend_p_q, pend_p_d, pend_m_q, pend_m_d;
  logic                       out_valid_q, out_valid_d;
  logic [gpbs_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                       out_bur_q, out_bur_d, out_occ_q, out_occ_d;
  logic                       out_oor_q, out_oor_d;

  logic in_acc, out_free;
  assign in_stall_o = (state_q != gpbs_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- walk eval
  gpbs_pkg::dir_t cur_dir, nxt_dir;
  logic [DW-1:0]  nxt_idx;
  logic [PW-1:0]  cur_dx, cur_dy, start_x, start_y;
  logic [PW-1:0]  koff, zp, zm;
  logic           p_in, m_in, bp, bm;
  logic           pend_p_n, pend_m_n, hit_p, hit_m, walk_fin, inxy_now;

  assign cur_dir = gpbs_pkg::dir_of(dir_q);
  assign nxt_idx = (state_q == gpbs_pkg::ST_WALK) ? DW'(dir_q + 1'b1) : '0;
  assign nxt_dir = gpbs_pkg::dir_of(nxt_idx);
  assign cur_dx  = PW'(cur_dir.dx);
  assign cur_dy  = PW'(cur_dir.dy);
  assign start_x = PW'(x_q) + PW'(nxt_dir.dx);
  assign start_y = PW'(y_q) + PW'(nxt_dir.dy);

  // z tracks; an underflowed zm wraps above every size
  assign koff = cur_dir.diag ? m_k_q : '0;
  assign zp   = PW'(z_q) + koff;
  assign zm   = PW'(z_q) - koff;
  assign p_in = zp < gz;
  assign m_in = zm < gz;
  assign bp   = p_in && rdata_q[zp[AW-1:0]];
  assign bm   = m_in && rdata_q[zm[AW-1:0]];

  assign inxy_now = (pos_x_q < gx) && (pos_y_q < gy);

  always_comb begin
    hit_p    = 1'b0;
    hit_m    = 1'b0;
    pend_p_n = pend_p_q;
    pend_m_n = pend_m_q;
    walk_fin = 1'b0;
    if (m_valid_q) begin
      if (!m_inxy_q) begin
        walk_fin = 1'b1;
      end else begin
        hit_p    = pend_p_q && bp;
        hit_m    = pend_m_q && bm;
        pend_p_n = pend_p_q && p_in && !bp;
        pend_m_n = pend_m_q && m_in && !bm;
        walk_fin = !pend_p_n && !pend_m_n;
      end
    end
  end

  // z line straight from the voxel's own row
  logic z_above, z_below;
  always_comb begin
    z_above = 1'b0;
    z_below = 1'b0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (rdata_q[j] && (PW'(j) > PW'(z_q)) && (PW'(j) < gz)) z_above = 1'b1;
      if (rdata_q[j] && (PW'(j) < PW'(z_q))) z_below = 1'b1;
    end
  end

  // seven lines: x, y, z axes, then the four body diagonals
  logic [gpbs_pkg::COUNT_W-1:0] line_cnt;
  assign line_cnt = gpbs_pkg::COUNT_W'(hp_q[0] & hp_q[1])
                  + gpbs_pkg::COUNT_W'(hp_q[2] & hp_q[3])
                  + gpbs_pkg::COUNT_W'(zup_q & zdn_q)
                  + gpbs_pkg::COUNT_W'(hp_q[4] & hm_q[5])
                  + gpbs_pkg::COUNT_W'(hm_q[4] & hp_q[5])
                  + gpbs_pkg::COUNT_W'(hp_q[6] & hm_q[7])
                  + gpbs_pkg::COUNT_W'(hm_q[6] & hp_q[7]);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gpbs_pkg::ST_CLEAR: begin
        if (clr_q == RAW'(DEPTH - 1)) state_d = gpbs_pkg::ST_IDLE;
      end
      gpbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (command_i == gpbs_pkg::CMD_WRITE) begin
            state_d = in_rng ? gpbs_pkg::ST_WR_RD : gpbs_pkg::ST_IDLE;
          end else begin
            state_d = in_rng ? gpbs_pkg::ST_Q_RD : gpbs_pkg::ST_DONE;
          end
        end
      end
      gpbs_pkg::ST_WR_RD: state_d = gpbs_pkg::ST_WR_WB;
      gpbs_pkg::ST_WR_WB: state_d = gpbs_pkg::ST_IDLE;
      gpbs_pkg::ST_Q_RD:  state_d = gpbs_pkg::ST_Q_EV;
      gpbs_pkg::ST_Q_EV: begin
        state_d = rdata_q[z_q] ? gpbs_pkg::ST_DONE : gpbs_pkg::ST_WALK;
      end
      gpbs_pkg::ST_WALK: begin
        if (walk_fin && (dir_q == DW'(gpbs_pkg::NUM_DIRS - 1))) state_d = gpbs_pkg::ST_DONE;
      end
      gpbs_pkg::ST_DONE: begin
        if (out_free) state_d = gpbs_pkg::ST_IDLE;
      end
      default: state_d = gpbs_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    clr_d     = clr_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    wocc_d    = wocc_q;
    oor_d     = oor_q;
    occf_d    = occf_q;
    zup_d     = zup_q;
    zdn_d     = zdn_q;
    hp_d      = hp_q;
    hm_d      = hm_q;
    dir_d     = dir_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    k_d       = k_q;
    m_k_d     = m_k_q;
    m_valid_d = m_valid_q;
    m_inxy_d  = m_inxy_q;
    pend_p_d  = pend_p_q;
    pend_m_d  = pend_m_q;
    out_cnt_d = out_cnt_q;
    out_bur_d = out_bur_q;
    out_occ_d = out_occ_q;
    out_oor_d = out_oor_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = row_addr(x_q, y_q);
    raddr     = row_addr(x_q, y_q);
    wdata     = rdata_q;

    case (state_q)
      gpbs_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + 1'b1;
      end
      gpbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          x_d    = cx9[AW-1:0];
          y_d    = cy9[AW-1:0];
          z_d    = cz9[AW-1:0];
          wocc_d = occupied_in_i;
          oor_d  = !in_rng;
          occf_d = 1'b0;
        end
      end
      gpbs_pkg::ST_WR_RD: mem_re = 1'b1;
      gpbs_pkg::ST_WR_WB: begin
        mem_we       = 1'b1;
        wdata[z_q]   = wocc_q;
      end
      gpbs_pkg::ST_Q_RD: mem_re = 1'b1;
      gpbs_pkg::ST_Q_EV: begin
        occf_d    = rdata_q[z_q];
        zup_d     = z_above;
        zdn_d     = z_below;
        hp_d      = '0;
        hm_d      = '0;
        dir_d     = '0;
        pos_x_d   = start_x;
        pos_y_d   = start_y;
        k_d       = PW'(1);
        m_valid_d = 1'b0;
        pend_p_d  = 1'b1;
        pend_m_d  = 1'b1;
      end
      gpbs_pkg::ST_WALK: begin
        // issue this step's row while the previous step's row is checked
        mem_re = 1'b1;
        raddr  = row_addr(pos_x_q[AW-1:0], pos_y_q[AW-1:0]);
        hp_d[dir_q] = hp_q[dir_q] | hit_p;
        hm_d[dir_q] = hm_q[dir_q] | hit_m;
        if (walk_fin) begin
          // drop the read in flight, restart at the next direction
          m_valid_d = 1'b0;
          dir_d     = nxt_idx;
          pos_x_d   = start_x;
          pos_y_d   = start_y;
          k_d       = PW'(1);
          pend_p_d  = 1'b1;
          pend_m_d  = 1'b1;
        end else begin
          m_valid_d = 1'b1;
          m_inxy_d  = inxy_now;
          m_k_d     = k_q;
          pos_x_d   = pos_x_q + cur_dx;
          pos_y_d   = pos_y_q + cur_dy;
          k_d       = k_q + 1'b1;
          pend_p_d  = pend_p_n;
          pend_m_d  = pend_m_n;
        end
      end
      gpbs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_oor_d   = oor_q;
          out_occ_d   = occf_q;
          out_cnt_d   = (oor_q || occf_q) ? '0 : line_cnt;
          out_bur_d   = !oor_q && !occf_q && (line_cnt >= thr_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gpbs_pkg::ST_CLEAR;
      clr_q       <= '0;
      dir_q       <= '0;
      k_q         <= '0;
      m_valid_q   <= 1'b0;
      pend_p_q    <= 1'b0;
      pend_m_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      dir_q       <= dir_d;
      k_q         <= k_d;
      m_valid_q   <= m_valid_d;
      pend_p_q    <= pend_p_d;
      pend_m_q    <= pend_m_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    wocc_q    <= wocc_d;
    oor_q     <= oor_d;
    occf_q    <= occf_d;
    zup_q     <= zup_d;
    zdn_q     <= zdn_d;
    hp_q      <= hp_d;
    hm_q      <= hm_d;
    pos_x_q   <= pos_x_d;
    pos_y_q   <= pos_y_d;
    m_k_q     <= m_k_d;
    m_inxy_q  <= m_inxy_d;
    out_cnt_q <= out_cnt_d;
    out_bur_q <= out_bur_d;
    out_occ_q <= out_occ_d;
    out_oor_q <= out_oor_d;
  end

  assign out_valid_o      = out_valid_q;
  assign enclosed_count_o = out_cnt_q;
  assign buried_o         = out_bur_q;
  assign voxel_occupied_o = out_occ_q;
  assign out_of_range_o   = out_oor_q;

  // ---------------------------------------------------------------- checks
  a_walk_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gpbs_pkg::ST_WALK) |-> !mem_we)
    else $error("memory write during line walk");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gpbs_pkg::ST_CLEAR) |-> !out_valid_q)
    else $error("result word during clearing pass");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_occ_q && out_oor_q))
    else $error("occupied and out-of-range both set");

  a_buried_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_occ_q || out_oor_q)) |-> (!out_bur_q && (out_cnt_q == '0)))
    else $error("count or buried set for occupied or out-of-range voxel");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result word lost");

endmodule

// ----- bench/grid_pocket_buriedness_scan_top_tb.sv -----
// ----------------------------------------------------------------------------
// grid_pocket_buriedness_scan_top_tb: self-checking bench for the pocket scan
// Drives write and query words with random idling on both sides, keeps its
// own voxel grid and line scan to predict query answers not fixed by the plan,
// and compares every result field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module grid_pocket_buriedness_scan_top_tb;
  import gpbs_pkg::*;

  localparam int DIM           = MAX_DIM_DEF;
  localparam int SCAN_LINES    = 7;
  localparam int PHASES        = 12;
  localparam int WORDS_PER_PH  = 106;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 20000;  // clear pass + long hold-off + slowest query
  localparam int PRESSURE_AT   = 150;
  localparam int PRESSURE_LEN  = 1500;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               buried;
    logic               occupied;
    logic               outside;
  } scan_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  cmd;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [COORD_W-1:0]    z;
    logic                  occ;
    bit                    typed;
    scan_result_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic w_cmd = 1'b0;
  logic [COORD_W-1:0] w_x = '0;
  logic [COORD_W-1:0] w_y = '0;
  logic [COORD_W-1:0] w_z = '0;
  logic w_occ = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COUNT_W-1:0] r_count;
  logic r_buried;
  logic r_occupied;
  logic r_outside;

  // shadow of the block's state
  bit occ_grid [0:DIM*DIM*DIM-1];
  logic [SIZE_REG_W-1:0] size_reg [3] = '{SIZE_RST, SIZE_RST, SIZE_RST};
  logic [THR_W-1:0] thr_reg = THR_RST;
  int line_step [SCAN_LINES][3] = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1},
                                    '{-1, -1, 1}, '{-1, -1, -1},
                                    '{1, -1, 1}, '{1, -1, -1}};

  scan_result_t pending_q [$];
  plan_row_t plan [$];
  int err_count = 0;
  int results_seen = 0;
  int tx_idle_pct = 26;
  int rx_idle_pct = 59;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  grid_pocket_buriedness_scan_top #(.MAX_DIM(DIM)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (w_cmd),
    .coord_x_i        (w_x),
    .coord_y_i        (w_y),
    .coord_z_i        (w_z),
    .occupied_in_i    (w_occ),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .enclosed_count_o (r_count),
    .buried_o         (r_buried),
    .voxel_occupied_o (r_occupied),
    .out_of_range_o   (r_outside)
  );

  // ---------------------------------------------------------------- predictor
  function automatic int eff_dim(logic [SIZE_REG_W-1:0] s);
    return (s > DIM) ? DIM : int'(s);
  endfunction

  function automatic int cell_index(int x, int y, int z);
    return (x * DIM + y) * DIM + z;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x < eff_dim(size_reg[0]) && y < eff_dim(size_reg[1]) &&
           z < eff_dim(size_reg[2]);
  endfunction

  // true if an occupied voxel lies on this side before the grid edge
  function automatic bit blocked_side(int x, int y, int z, int dx, int dy, int dz);
    int px, py, pz, gx, gy, gz;
    gx = eff_dim(size_reg[0]);
    gy = eff_dim(size_reg[1]);
    gz = eff_dim(size_reg[2]);
    px = x + dx;
    py = y + dy;
    pz = z + dz;
    while (px >= 0 && px < gx && py >= 0 && py < gy && pz >= 0 && pz < gz) begin
      if (occ_grid[cell_index(px, py, pz)]) return 1'b1;
      px += dx;
      py += dy;
      pz += dz;
    end
    return 1'b0;
  endfunction

  function automatic scan_result_t predict_scan(int x, int y, int z);
    scan_result_t r;
    int hits;
    r = '0;
    hits = 0;
    if (!in_grid(x, y, z)) begin
      r.outside = 1'b1;
      return r;
    end
    if (occ_grid[cell_index(x, y, z)]) begin
      r.occupied = 1'b1;
      return r;
    end
    for (int i = 0; i < SCAN_LINES; i++) begin
      if (blocked_side(x, y, z, line_step[i][0], line_step[i][1], line_step[i][2]) &&
          blocked_side(x, y, z, -line_step[i][0], -line_step[i][1], -line_step[i][2]))
        hits++;
    end
    r.count = hits[COUNT_W-1:0];
    r.buried = (hits >= thr_reg);
    return r;
  endfunction

  function automatic void expect_result(scan_result_t res);
    pending_q.insert(pending_q.size(), res);
  endfunction

  function automatic void take_word(logic cmd, int x, int y, int z, logic occ,
                                    bit typed, scan_result_t want);
    if (cmd == CMD_WRITE) begin
      if (in_grid(x, y, z)) occ_grid[cell_index(x, y, z)] = occ;
    end else begin
      expect_result(typed ? want : predict_scan(x, y, z));
    end
  endfunction

  // ---------------------------------------------------------------- plan rows
  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic plan_row_t mk_word(logic cmd, int x, int y, int z, logic occ);
    plan_row_t r;
    r.kind = ROW_WORD;
    r.reg_idx = CFG_SIZE_X;
    r.reg_val = '0;
    r.cmd = cmd;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.z = COORD_W'(z);
    r.occ = occ;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t mk_check(int x, int y, int z, int cnt, bit bur,
                                         bit occ, bit oor);
    plan_row_t r;
    r = mk_word(CMD_QUERY, x, y, z, 1'b0);
    r.typed = 1'b1;
    r.want = '{count: cnt[COUNT_W-1:0], buried: bur, occupied: occ, outside: oor};
    return r;
  endfunction

  function automatic plan_row_t mk_reg(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r = mk_word(CMD_WRITE, 0, 0, 0, 1'b0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_word(logic cmd, int x, int y, int z, logic occ, bit typed,
                           scan_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    w_cmd <= cmd;
    w_x <= COORD_W'(x);
    w_y <= COORD_W'(y);
    w_z <= COORD_W'(z);
    w_occ <= occ;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_word(cmd, x, y, z, occ, typed, want);
  endtask

  // caller drops cfg_we after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SIZE_X: size_reg[0] = val;
      CFG_SIZE_Y: size_reg[1] = val;
      CFG_SIZE_Z: size_reg[2] = val;
      CFG_THR:    thr_reg = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // wait for all answers, then let a trailing write finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return DIM;
      3: return $urandom_range(DIM + 1, 127);
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want,
             results_seen);
    err_count++;
  endtask

  task automatic check_result();
    scan_result_t want;
    if (pending_q.size() == 0) begin
      report_mismatch("word with nothing pending", 1, 0);
      return;
    end
    want = pending_q.pop_front();
    if (r_count !== want.count) report_mismatch("enclosed_count", r_count, want.count);
    if (r_buried !== want.buried) report_mismatch("buried", r_buried, want.buried);
    if (r_occupied !== want.occupied)
      report_mismatch("voxel_occupied", r_occupied, want.occupied);
    if (r_outside !== want.outside)
      report_mismatch("out_of_range", r_outside, want.outside);
  endtask

  initial begin : result_side
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!pressure_done && results_seen == PRESSURE_AT) begin
        hold_left = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_pocket_buriedness_scan_top_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int gx, gy, gz, density;
    logic cmd, occ;
    int x, y, z;

    // empty grid at reset sizes
    add_row(mk_check(0, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    add_row(mk_check(63, 63, 63, 0, 1'b0, 1'b0, 1'b0));
    // wall in (1,1,1) on both sides of every line
    for (int i = 0; i < SCAN_LINES; i++) begin
      add_row(mk_word(CMD_WRITE, 1 + line_step[i][0], 1 + line_step[i][1],
                      1 + line_step[i][2], 1'b1));
      add_row(mk_word(CMD_WRITE, 1 - line_step[i][0], 1 - line_step[i][1],
                      1 - line_step[i][2], 1'b1));
    end
    add_row(mk_check(1, 1, 1, 7, 1'b1, 1'b0, 1'b0));
    add_row(mk_check(0, 0, 0, 0, 1'b0, 1'b1, 1'b0));
    add_row(mk_word(CMD_WRITE, 0, 0, 0, 1'b0));
    add_row(mk_word(CMD_QUERY, 1, 1, 1, 1'b0));
    // threshold zero: a corner voxel sees no closed line yet is buried
    add_row(mk_reg(CFG_THR, 0));
    add_row(mk_check(63, 63, 63, 0, 1'b1, 1'b0, 1'b0));
    // shrunk x: write past the edge is dropped
    add_row(mk_reg(CFG_SIZE_X, 2));
    add_row(mk_word(CMD_WRITE, 5, 1, 1, 1'b1));
    add_row(mk_word(CMD_QUERY, 1, 1, 1, 1'b0));
    add_row(mk_reg(CFG_SIZE_X, 0));
    add_row(mk_check(0, 0, 0, 0, 1'b0, 1'b0, 1'b1));
    // oversize register saturates to the full edge
    add_row(mk_reg(CFG_SIZE_X, 127));
    add_row(mk_check(63, 63, 63, 0, 1'b1, 1'b0, 1'b0));
    add_row(mk_word(CMD_QUERY, 5, 1, 1, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_we <= 1'b0;
      end else begin
        send_word(plan[i].cmd, plan[i].x, plan[i].y, plan[i].z, plan[i].occ,
                  plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 4) begin
        tx_idle_pct = 26;
        rx_idle_pct = 59;
      end else if (ph < 8) begin
        tx_idle_pct = 59;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(CFG_SIZE_X, CFG_DATA_W'(pick_size()));
      write_reg(CFG_SIZE_Y, CFG_DATA_W'(pick_size()));
      write_reg(CFG_SIZE_Z, CFG_DATA_W'(pick_size()));
      write_reg(CFG_THR, CFG_DATA_W'((ph == 1) ? 7 : $urandom_range(0, 7)));
      cfg_we <= 1'b0;
      gx = eff_dim(size_reg[0]);
      gy = eff_dim(size_reg[1]);
      gz = eff_dim(size_reg[2]);
      density = $urandom_range(20, 70);
      for (int n = 0; n < WORDS_PER_PH; n++) begin
        if ($urandom_range(0, 9) == 0 || gx == 0 || gy == 0 || gz == 0) begin
          // noise: any coordinate, any command
          cmd = 1'($urandom_range(0, 1));
          occ = 1'($urandom_range(0, 1));
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
          z = $urandom_range(0, 63);
        end else begin
          cmd = ($urandom_range(0, 99) < 45) ? CMD_QUERY : CMD_WRITE;
          occ = ($urandom_range(0, 99) < density);
          x = $urandom_range(0, gx - 1);
          y = $urandom_range(0, gy - 1);
          z = $urandom_range(0, gz - 1);
        end
        send_word(cmd, x, y, z, occ, 1'b0, '0);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("grid_pocket_buriedness_scan_top_tb: done, clean");
    end else begin
      $display("grid_pocket_buriedness_scan_top_tb: done, errors");
    end
    $finish;
  end

endmodule
